>>> rtl/ppbc_pkg.sv
// Package with the shared types, mode codes and command codes of the panel controller.
`default_nettype none
package ppbc_pkg;

  localparam int MaxCmd = 5;
  localparam int CntW = $clog2(MaxCmd + 1);

  localparam logic [2:0] M_IDLE        = 3'd0;
  localparam logic [2:0] M_PRINTING    = 3'd1;
  localparam logic [2:0] M_PRE_FEED    = 3'd2;
  localparam logic [2:0] M_PRE_RETRACT = 3'd3;
  localparam logic [2:0] M_FEEDING     = 3'd4;
  localparam logic [2:0] M_RETRACTING  = 3'd5;
  localparam logic [2:0] M_LEVELING    = 3'd6;

  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_HOME     = 4'd1;
  localparam logic [3:0] CMD_ABS      = 4'd2;
  localparam logic [3:0] CMD_HEAT_ON  = 4'd3;
  localparam logic [3:0] CMD_HEAT_OFF = 4'd4;
  localparam logic [3:0] CMD_QSTOP    = 4'd5;
  localparam logic [3:0] CMD_REL      = 4'd6;
  localparam logic [3:0] CMD_FEED     = 4'd7;
  localparam logic [3:0] CMD_RETRACT  = 4'd8;
  localparam logic [3:0] CMD_CORNER0  = 4'd9;

  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_LOCK   = 2'd1;
  localparam logic [1:0] REG_SLOW   = 2'd2;
  localparam logic [1:0] REG_FAST   = 2'd3;

  localparam logic [3:0] LED_RESET = 4'b1110;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               home_pressed;
    logic               plus_pressed;
    logic               minus_pressed;
    logic               printing_active;
    logic signed [13:0] hotend_temp;
    logic               queue_empty;
  } item_t;

  typedef struct packed {
    logic [12:0] preheat_threshold;
    logic [15:0] key_lockout_ms;
    logic [15:0] slow_blink_ms;
    logic [15:0] fast_blink_ms;
  } cfg_t;

  typedef struct packed {
    logic [MaxCmd-1:0][3:0] cmd;
    logic [CntW-1:0]        cnt;
    logic [3:0]             led;
  } batch_t;

  function automatic batch_t push(batch_t b, logic [3:0] c);
    batch_t r;
    r = b;
    if (r.cnt < CntW'(MaxCmd)) begin
      r.cmd[r.cnt] = c;
      r.cnt = r.cnt + CntW'(1);
    end
    return r;
  endfunction

  function automatic logic passed(logic [31:0] now, logic [31:0] due);
    logic [31:0] d;
    d = now - due;
    return ~d[31];
  endfunction

endpackage
`default_nettype wire

>>> rtl/ppbc_core.sv
// Per-tick step logic and the panel state registers.
`default_nettype none
module ppbc_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire ppbc_pkg::item_t item,
  input  wire ppbc_pkg::cfg_t  cfg,
  output ppbc_pkg::batch_t     batch
);

  logic [2:0]  mode_r, mode_nxt;
  logic [1:0]  corner_r, corner_nxt;
  logic [31:0] rel_r [3];
  logic [31:0] rel_nxt [3];
  logic [31:0] slow_due_r, slow_due_nxt;
  logic [31:0] fast_due_r, fast_due_nxt;
  logic [3:0]  led_r, led_nxt;

  always_comb begin
    logic [2:0] m;
    logic [1:0] c;
    logic hot, slow, fast;
    logic [2:0] keys;
    ppbc_pkg::batch_t b;
    m = mode_r;
    c = corner_r;
    b = '0;
    keys = {item.minus_pressed, item.plus_pressed, item.home_pressed};
    hot = item.hotend_temp >= $signed({1'b0, cfg.preheat_threshold});
    for (int k = 0; k < 3; k++) begin
      rel_nxt[k] = rel_r[k];
    end

    if (keys[0] && ppbc_pkg::passed(item.now_ms, rel_r[0])) begin
      if (m == ppbc_pkg::M_IDLE) begin
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_HOME);
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_ABS);
        m = ppbc_pkg::M_LEVELING;
      end else if (m == ppbc_pkg::M_LEVELING) begin
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_HOME);
        m = ppbc_pkg::M_IDLE;
      end
      rel_nxt[0] = item.now_ms + {16'd0, cfg.key_lockout_ms};
    end

    if (keys[1] && ppbc_pkg::passed(item.now_ms, rel_r[1])) begin
      if (m == ppbc_pkg::M_IDLE) begin
        m = ppbc_pkg::M_PRE_FEED;
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_HEAT_ON);
      end else if (m == ppbc_pkg::M_PRE_FEED || m == ppbc_pkg::M_FEEDING) begin
        m = ppbc_pkg::M_IDLE;
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_QSTOP);
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_HEAT_OFF);
      end else if (m == ppbc_pkg::M_LEVELING) begin
        c = c + 2'd1;
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_CORNER0 + {2'd0, c});
      end
      rel_nxt[1] = item.now_ms + {16'd0, cfg.key_lockout_ms};
    end

    if (keys[2] && ppbc_pkg::passed(item.now_ms, rel_r[2])) begin
      if (m == ppbc_pkg::M_IDLE) begin
        m = ppbc_pkg::M_PRE_RETRACT;
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_HEAT_ON);
      end else if (m == ppbc_pkg::M_PRE_RETRACT || m == ppbc_pkg::M_RETRACTING) begin
        m = ppbc_pkg::M_IDLE;
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_QSTOP);
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_HEAT_OFF);
      end else if (m == ppbc_pkg::M_LEVELING) begin
        c = c + 2'd3;
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_CORNER0 + {2'd0, c});
      end
      rel_nxt[2] = item.now_ms + {16'd0, cfg.key_lockout_ms};
    end

    priority if (item.printing_active) begin
      m = ppbc_pkg::M_PRINTING;
    end else if (m == ppbc_pkg::M_PRINTING) begin
      m = ppbc_pkg::M_IDLE;
    end else if (m == ppbc_pkg::M_PRE_FEED && hot) begin
      b = ppbc_pkg::push(b, ppbc_pkg::CMD_REL);
      m = ppbc_pkg::M_FEEDING;
    end else if (m == ppbc_pkg::M_PRE_RETRACT && hot) begin
      b = ppbc_pkg::push(b, ppbc_pkg::CMD_REL);
      b = ppbc_pkg::push(b, ppbc_pkg::CMD_FEED);
      m = ppbc_pkg::M_RETRACTING;
    end else begin
    end

    slow = ppbc_pkg::passed(item.now_ms, slow_due_r);
    fast = ppbc_pkg::passed(item.now_ms, fast_due_r);
    slow_due_nxt = slow ? item.now_ms + {16'd0, cfg.slow_blink_ms} : slow_due_r;
    fast_due_nxt = fast ? item.now_ms + {16'd0, cfg.fast_blink_ms} : fast_due_r;

    led_nxt = ppbc_pkg::LED_RESET;
    unique case (m)
      ppbc_pkg::M_PRINTING:    led_nxt[0] = led_r[0] ^ slow;
      ppbc_pkg::M_PRE_FEED:    led_nxt[1] = led_r[1] ^ fast;
      ppbc_pkg::M_FEEDING:     led_nxt[1] = led_r[1] ^ slow;
      ppbc_pkg::M_PRE_RETRACT: led_nxt[2] = led_r[2] ^ fast;
      ppbc_pkg::M_RETRACTING:  led_nxt[2] = led_r[2] ^ slow;
      ppbc_pkg::M_LEVELING:    led_nxt = 4'b0110;
      default:                 led_nxt = ppbc_pkg::LED_RESET;
    endcase

    if (b.cnt == '0 && item.queue_empty) begin
      if (m == ppbc_pkg::M_FEEDING) begin
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_FEED);
      end else if (m == ppbc_pkg::M_RETRACTING) begin
        b = ppbc_pkg::push(b, ppbc_pkg::CMD_RETRACT);
      end
    end
    if (b.cnt == '0) begin
      b = ppbc_pkg::push(b, ppbc_pkg::CMD_NONE);
    end
    b.led = led_nxt;

    mode_nxt = m;
    corner_nxt = c;
    batch = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ppbc_pkg::M_IDLE;
      corner_r <= 2'd0;
      for (int k = 0; k < 3; k++) begin
        rel_r[k] <= 32'd0;
      end
      slow_due_r <= 32'd0;
      fast_due_r <= 32'd0;
      led_r <= ppbc_pkg::LED_RESET;
    end else if (step) begin
      mode_r <= mode_nxt;
      corner_r <= corner_nxt;
      for (int k = 0; k < 3; k++) begin
        rel_r[k] <= rel_nxt[k];
      end
      slow_due_r <= slow_due_nxt;
      fast_due_r <= fast_due_nxt;
      led_r <= led_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ppbc_drain.sv
// Result register that holds one tick's commands and hands them out one a cycle while out_ready is high.
`default_nettype none
module ppbc_drain (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire ppbc_pkg::batch_t batch_in,
  output logic                 free,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [3:0]           out_command,
  output logic [3:0]           out_led,
  output logic                 out_last
);

  ppbc_pkg::batch_t batch_r;
  logic valid_r;
  logic [ppbc_pkg::CntW-1:0] idx_r;

  assign out_valid = valid_r;
  assign out_command = batch_r.cmd[idx_r];
  assign out_led = batch_r.led;
  assign out_last = (idx_r == batch_r.cnt - ppbc_pkg::CntW'(1));
  assign free = !valid_r || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r <= '0;
    end else if (valid_r && out_ready) begin
      if (out_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + ppbc_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      batch_r <= batch_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/printer_panel_button_controller.sv
// Top level of the printer front-panel controller: input register, step logic and result drain.
//
//   channel | direction | handshake             | payload
//   in_     | request   | in_valid / in_ready   | tick time, key levels, printing, temp, queue
//   out_    | result    | out_valid / out_ready | command, four LED levels, last
//   cfg_    | write     | cfg_valid / cfg_ready | register index, data
//
// A request is registered, stepped by the core logic and its results loaded into the result register.
// A tick gives one to five results, sent one a cycle while out_ready is high.
// One more request is taken into the input register while results wait; stepping holds until the result register frees.
// Reset is synchronous and active low; configuration writes are always taken.
`default_nettype none
module printer_panel_button_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        in_home_pressed,
  input  wire logic        in_plus_pressed,
  input  wire logic        in_minus_pressed,
  input  wire logic        in_printing_active,
  input  wire logic signed [13:0] in_hotend_temp,
  input  wire logic        in_queue_empty,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_command,
  output logic             out_led_start,
  output logic             out_led_plus,
  output logic             out_led_minus,
  output logic             out_led_home,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  ppbc_pkg::item_t  item_r;
  logic             in_v_r;
  ppbc_pkg::cfg_t   cfg_r;
  ppbc_pkg::batch_t batch;
  logic             free;
  logic             step;
  logic [3:0]       led;

  assign step = in_v_r && free;
  assign in_ready = !in_v_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.now_ms <= in_now_ms;
      item_r.home_pressed <= in_home_pressed;
      item_r.plus_pressed <= in_plus_pressed;
      item_r.minus_pressed <= in_minus_pressed;
      item_r.printing_active <= in_printing_active;
      item_r.hotend_temp <= in_hotend_temp;
      item_r.queue_empty <= in_queue_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preheat_threshold <= 13'd2190;
      cfg_r.key_lockout_ms <= 16'd1000;
      cfg_r.slow_blink_ms <= 16'd500;
      cfg_r.fast_blink_ms <= 16'd75;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ppbc_pkg::REG_THRESH: cfg_r.preheat_threshold <= cfg_data[12:0];
        ppbc_pkg::REG_LOCK:   cfg_r.key_lockout_ms <= cfg_data;
        ppbc_pkg::REG_SLOW:   cfg_r.slow_blink_ms <= cfg_data;
        ppbc_pkg::REG_FAST:   cfg_r.fast_blink_ms <= cfg_data;
        default:              cfg_r <= cfg_r;
      endcase
    end
  end

  ppbc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg_r),
    .batch (batch)
  );

  ppbc_drain u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (step),
    .batch_in    (batch),
    .free        (free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_command (out_command),
    .out_led     (led),
    .out_last    (out_last)
  );

  assign out_led_start = led[0];
  assign out_led_plus  = led[1];
  assign out_led_minus = led[2];
  assign out_led_home  = led[3];

  a_step_loads: assert property (@(posedge clk) disable iff (!rst_n) step |=> out_valid)
    else $error("stepped request did not produce a result");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("result run ended before its last result");

  a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command == ppbc_pkg::CMD_NONE) |-> out_last)
    else $error("empty command sent within a run");

endmodule
`default_nettype wire
